[hdl/gpfp_pkg.sv]
// Shared types, constants and register codes for the plume field probe.
package gpfp_pkg;

    localparam int MAX_GRID_SIDE = 1024;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_X        = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_Y        = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_AMPLITUDE = 4'd7;

    localparam logic [15:0] RST_CELL_SIZE      = 16'd102;
    localparam logic [10:0] RST_GRID_COLUMNS   = 11'd1;
    localparam logic [10:0] RST_GRID_ROWS      = 11'd1;
    localparam logic [31:0] RST_DECAY_X        = 32'd819;
    localparam logic [31:0] RST_DECAY_Y        = 32'd32768;
    localparam logic [31:0] RST_PEAK_AMPLITUDE = 32'd16492134;

    localparam logic [4:0]  STEP_FIRST = 5'd1;
    localparam logic [4:0]  STEP_LAST  = 5'd25;
    localparam logic [4:0]  STEP_WRAP  = 5'd20;
    localparam logic [7:0]  WIND_HIT   = 8'd128;
    localparam logic [31:0] Q31_ONE    = 32'h8000_0000;
    localparam int          EXP_LIMIT_BIT = 21;

    // Reciprocals scaled by 2^32; the upper product word is the exact floor
    // quotient for any dividend below 2^28.
    localparam logic [31:0] RECIP_3 = 32'd1431655766;
    localparam logic [31:0] RECIP_5 = 32'd858993460;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic signed [23:0] query_x;
        logic signed [23:0] query_y;
        logic signed [23:0] query_z;
    } in_item_t;

    typedef struct packed {
        logic        cell_found;
        logic [31:0] concentration;
        logic [7:0]  wind_speed;
        logic [9:0]  cell_column;
        logic [9:0]  cell_row;
    } out_item_t;

    typedef struct packed {
        logic signed [23:0] source_x;
        logic signed [23:0] source_y;
        logic [15:0]        cell_size;
        logic [10:0]        grid_columns;
        logic [10:0]        grid_rows;
        logic [31:0]        decay_x;
        logic [31:0]        decay_y;
        logic [31:0]        peak_amplitude;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        logic     is_tick;
        in_item_t item;
    } front_head_t;

endpackage

[hdl/gpfp_front.sv]
// Front end: accepts items, tags ticks and holds them in a short queue.
module gpfp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gpfp_pkg::in_item_t    s_item,
    output gpfp_pkg::front_head_t head,
    input  logic                  pop
);

    localparam int DEPTH = gpfp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic               is_tick;
        gpfp_pkg::in_item_t item;
    } entry_t;

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, do_pop;

    assign s_ready = (count_reg != CNT_W'(DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid   = (count_reg != '0);
    assign head.is_tick = mem_reg[rd_ptr_reg].is_tick;
    assign head.item    = mem_reg[rd_ptr_reg].item;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg].is_tick <= (s_item.opcode == gpfp_pkg::OP_TICK);
            mem_reg[wr_ptr_reg].item    <= s_item;
        end
    end

endmodule

[hdl/gpfp_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module gpfp_div #(
    parameter int N = 53,
    parameter int D = 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [N-1:0]              dividend,
    input  logic [$clog2(N+1)-1:0]    len,
    input  logic [D-1:0]              divisor,
    output logic                      done,
    output logic [N-1:0]              quotient
);

    localparam int LEN_W = $clog2(N + 1);

    logic [D:0]       rem_reg, rem_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [D-1:0]     dvs_reg, dvs_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D:0]       rem_sh;
    logic [LEN_W-1:0] shamt;

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign shamt    = LEN_W'(N) - len;
    assign rem_sh   = {rem_reg[D-1:0], quo_reg[N-1]};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend << shamt;
            dvs_next  = divisor;
            cnt_next  = len;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == LEN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

[hdl/gpfp_back.sv]
// Back end: sequencer with one shared multiplier and a serial divider.
module gpfp_back #(
    parameter int MAX_GRID_SIDE = gpfp_pkg::MAX_GRID_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpfp_pkg::cfg_t        cfg,
    input  gpfp_pkg::front_head_t head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gpfp_pkg::out_item_t   m_item
);

    localparam int IDX_W  = (MAX_GRID_SIDE > 2) ? $clog2(MAX_GRID_SIDE) : 1;
    localparam int S_W    = 32 + 2 * IDX_W + 1;
    localparam int DIV_N  = S_W;
    localparam int DIV_D  = 17;
    localparam int LEN_W  = $clog2(DIV_N + 1);
    localparam int CMP_W  = 18;

    typedef enum logic [29:0] {
        ST_IDLE = 30'b1 << 0,  ST_IX  = 30'b1 << 1,  ST_IXW = 30'b1 << 2,
        ST_IY   = 30'b1 << 3,  ST_IYW = 30'b1 << 4,  ST_CS  = 30'b1 << 5,
        ST_CX   = 30'b1 << 6,  ST_CY  = 30'b1 << 7,  ST_SQX = 30'b1 << 8,
        ST_SQY  = 30'b1 << 9,  ST_SQZ = 30'b1 << 10, ST_CMP = 30'b1 << 11,
        ST_II   = 30'b1 << 12, ST_JJ  = 30'b1 << 13, ST_DX  = 30'b1 << 14,
        ST_DY   = 30'b1 << 15, ST_SUM = 30'b1 << 16, ST_E   = 30'b1 << 17,
        ST_EW   = 30'b1 << 18, ST_V5  = 30'b1 << 19, ST_V5W = 30'b1 << 20,
        ST_VT   = 30'b1 << 21, ST_VD  = 30'b1 << 22, ST_VW  = 30'b1 << 23,
        ST_TT   = 30'b1 << 24, ST_TS  = 30'b1 << 25, ST_PK  = 30'b1 << 26,
        ST_PD   = 30'b1 << 27, ST_PW  = 30'b1 << 28, ST_OUT = 30'b1 << 29
    } state_t;

    function automatic logic [16:0] sat_abs(input logic signed [33:0] v);
        logic [33:0] a;
        a = v[33] ? 34'(-v) : 34'(v);
        return (a[33:17] != '0) ? 17'h1FFFF : a[16:0];
    endfunction

    state_t                state_reg, state_next;
    logic [4:0]            next_step_reg, next_step_next;
    logic [4:0]            field_step_reg, field_step_next;
    logic signed [24:0]    dx0_reg, dx0_next, dy0_reg, dy0_next;
    logic [16:0]           ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [IDX_W-1:0]      ci_reg, ci_next, cj_reg, cj_next;
    logic [63:0]           prod_reg;
    logic [S_W-1:0]        acc_reg, acc_next;
    logic [35:0]           dist_reg, dist_next;
    logic [31:0]           sq_reg, sq_next, cs2_reg, cs2_next, t_reg, t_next;
    logic [27:0]           v_reg, v_next;
    logic [2:0]            term_reg, term_next;
    logic [2:0]            sqcnt_reg, sqcnt_next;
    logic                  found_reg, found_next;
    logic [31:0]           conc_reg, conc_next;
    logic                  out_valid_reg, out_valid_next;
    gpfp_pkg::out_item_t   out_reg, out_next;

    logic [31:0]           mul_a, mul_b;
    logic                  div_start, div_done;
    logic [DIV_N-1:0]      div_dividend, div_quo;
    logic [LEN_W-1:0]      div_len;
    logic [DIV_D-1:0]      div_divisor;

    logic [CMP_W-1:0]      max_side, cnt_x, cnt_y, gx, gy;
    logic [IDX_W-1:0]      last_x, last_y;
    logic signed [26:0]    n_sel;
    logic [27:0]           num_sel;
    logic [IDX_W-1:0]      idx_clamp;
    logic [IDX_W-1:0]      last_sel;
    logic signed [24:0]    d_sel;
    logic signed [33:0]    dfull;
    logic [35:0]           d2;
    logic [27:0]           x_term;
    logic [31:0]           ci_ext, cj_ext;
    logic signed [24:0]    qx_ext, qy_ext, sx_ext, sy_ext;
    logic [23:0]           qz_abs;

    assign max_side = CMP_W'(MAX_GRID_SIDE);
    assign gx       = CMP_W'(cfg.grid_columns);
    assign gy       = CMP_W'(cfg.grid_rows);
    assign cnt_x    = (gx > max_side) ? max_side : gx;
    assign cnt_y    = (gy > max_side) ? max_side : gy;
    assign last_x   = IDX_W'(cnt_x - 1'b1);
    assign last_y   = IDX_W'(cnt_y - 1'b1);

    assign qx_ext = 25'(head.item.query_x);
    assign qy_ext = 25'(head.item.query_y);
    assign sx_ext = 25'(cfg.source_x);
    assign sy_ext = 25'(cfg.source_y);
    assign qz_abs = head.item.query_z[23] ? 24'(-head.item.query_z)
                                           : 24'(head.item.query_z);

    // Round-half-down index: ceil((2d - cs) / 2cs) when positive, else zero.
    assign d_sel   = (state_reg == ST_IX) ? dx0_reg : dy0_reg;
    assign n_sel   = (27'(d_sel) <<< 1) - $signed({11'b0, cfg.cell_size});
    assign num_sel = (n_sel > 0) ? 28'(n_sel) + {11'b0, cfg.cell_size, 1'b0} - 28'd1
                                 : 28'd0;
    assign last_sel  = (state_reg == ST_IXW) ? last_x : last_y;
    assign idx_clamp = (div_quo > DIV_N'(last_sel)) ? last_sel : div_quo[IDX_W-1:0];

    assign dfull  = 34'((state_reg == ST_CY) ? dx0_reg : dy0_reg)
                  - $signed({1'b0, prod_reg[32:0]});
    assign d2     = dist_reg + prod_reg[35:0];
    assign x_term = prod_reg[58:31];
    assign ci_ext = 32'(ci_reg);
    assign cj_ext = 32'(cj_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CS:   begin mul_a = 32'(cfg.cell_size); mul_b = 32'(cfg.cell_size); end
            ST_CX:   begin mul_a = 32'(cfg.cell_size); mul_b = ci_ext; end
            ST_CY:   begin mul_a = 32'(cfg.cell_size); mul_b = cj_ext; end
            ST_SQX:  begin mul_a = 32'(ax_reg); mul_b = 32'(ax_reg); end
            ST_SQY:  begin mul_a = 32'(ay_reg); mul_b = 32'(ay_reg); end
            ST_SQZ:  begin mul_a = 32'(az_reg); mul_b = 32'(az_reg); end
            ST_II:   begin mul_a = ci_ext; mul_b = ci_ext; end
            ST_JJ:   begin mul_a = cj_ext; mul_b = cj_ext; end
            ST_DX:   begin mul_a = cfg.decay_x; mul_b = sq_reg; end
            ST_DY:   begin mul_a = cfg.decay_y; mul_b = sq_reg; end
            ST_V5:   begin mul_a = 32'(v_reg); mul_b = gpfp_pkg::RECIP_5; end
            ST_VT:   begin mul_a = 32'(v_reg); mul_b = t_reg; end
            ST_VD:   begin mul_a = 32'(x_term); mul_b = gpfp_pkg::RECIP_3; end
            ST_TT:   begin mul_a = t_reg; mul_b = t_reg; end
            ST_PK:   begin mul_a = cfg.peak_amplitude; mul_b = t_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next      = state_reg;
        next_step_next  = next_step_reg;
        field_step_next = field_step_reg;
        dx0_next   = dx0_reg;
        dy0_next   = dy0_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        ci_next    = ci_reg;
        cj_next    = cj_reg;
        acc_next   = acc_reg;
        dist_next  = dist_reg;
        sq_next    = sq_reg;
        cs2_next   = cs2_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        term_next  = term_reg;
        sqcnt_next = sqcnt_reg;
        found_next = found_reg;
        conc_next  = conc_reg;
        out_valid_next = out_valid_reg;
        out_next   = out_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_len      = '0;
        div_divisor  = '0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop = 1'b1;
                    if (head.is_tick) begin
                        field_step_next = next_step_reg;
                        next_step_next  = (next_step_reg >= gpfp_pkg::STEP_LAST)
                                        ? gpfp_pkg::STEP_WRAP : next_step_reg + 1'b1;
                    end else begin
                        dx0_next   = qx_ext - sx_ext;
                        dy0_next   = qy_ext - sy_ext;
                        az_next    = (qz_abs[23:17] != '0) ? 17'h1FFFF : qz_abs[16:0];
                        found_next = 1'b0;
                        conc_next  = '0;
                        if (cfg.cell_size == '0 || cnt_x == '0 || cnt_y == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_IX;
                        end
                    end
                end
            end
            ST_IX, ST_IY: begin
                div_start    = 1'b1;
                div_dividend = DIV_N'(num_sel);
                div_len      = LEN_W'(28);
                div_divisor  = {cfg.cell_size, 1'b0};
                state_next   = (state_reg == ST_IX) ? ST_IXW : ST_IYW;
            end
            ST_IXW: begin
                if (div_done) begin
                    ci_next    = idx_clamp;
                    state_next = ST_IY;
                end
            end
            ST_IYW: begin
                if (div_done) begin
                    cj_next    = idx_clamp;
                    state_next = ST_CS;
                end
            end
            ST_CS:  state_next = ST_CX;
            ST_CX: begin
                cs2_next   = prod_reg[31:0];
                state_next = ST_CY;
            end
            ST_CY: begin
                ax_next    = sat_abs(dfull);
                state_next = ST_SQX;
            end
            ST_SQX: begin
                ay_next    = sat_abs(dfull);
                state_next = ST_SQY;
            end
            ST_SQY: begin
                dist_next  = prod_reg[35:0];
                state_next = ST_SQZ;
            end
            ST_SQZ: begin
                dist_next  = dist_reg + prod_reg[35:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (d2 >= 36'(cs2_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    found_next = 1'b1;
                    state_next = (field_step_reg == '0) ? ST_OUT : ST_II;
                end
            end
            ST_II:  state_next = ST_JJ;
            ST_JJ: begin
                sq_next    = prod_reg[31:0];
                state_next = ST_DX;
            end
            ST_DX: begin
                sq_next    = prod_reg[31:0];
                state_next = ST_DY;
            end
            ST_DY: begin
                acc_next   = S_W'(prod_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                acc_next   = acc_reg + S_W'(prod_reg);
                state_next = ST_E;
            end
            ST_E: begin
                div_start    = 1'b1;
                div_dividend = acc_reg;
                div_len      = LEN_W'(S_W);
                div_divisor  = DIV_D'(field_step_reg);
                state_next   = ST_EW;
            end
            ST_EW: begin
                if (div_done) begin
                    if (div_quo[DIV_N-1:gpfp_pkg::EXP_LIMIT_BIT] != '0) begin
                        state_next = ST_OUT;
                    end else begin
                        v_next     = {div_quo[gpfp_pkg::EXP_LIMIT_BIT-1:0], 7'b0};
                        state_next = ST_V5;
                    end
                end
            end
            ST_V5:  state_next = ST_V5W;
            ST_V5W: begin
                t_next     = gpfp_pkg::Q31_ONE - prod_reg[63:32];
                term_next  = 3'd4;
                state_next = ST_VT;
            end
            ST_VT:  state_next = ST_VD;
            ST_VD: begin
                // Horner terms divide by 4, 3, 2 and 1 in turn; the second uses a
                // reciprocal product that is ready in the next state.
                unique case (term_reg)
                    3'd4: t_next = gpfp_pkg::Q31_ONE - 32'(x_term >> 2);
                    3'd2: t_next = gpfp_pkg::Q31_ONE - 32'(x_term >> 1);
                    3'd1: t_next = gpfp_pkg::Q31_ONE - 32'(x_term);
                    default: ;
                endcase
                term_next  = term_reg - 1'b1;
                sqcnt_next = '0;
                if (term_reg == 3'd3) begin
                    state_next = ST_VW;
                end else if (term_reg == 3'd1) begin
                    state_next = ST_TT;
                end else begin
                    state_next = ST_VT;
                end
            end
            ST_VW: begin
                t_next     = gpfp_pkg::Q31_ONE - prod_reg[63:32];
                state_next = ST_VT;
            end
            ST_TT:  state_next = ST_TS;
            ST_TS: begin
                t_next     = prod_reg[62:31];
                sqcnt_next = sqcnt_reg + 1'b1;
                state_next = (sqcnt_reg == 3'd7) ? ST_PK : ST_TT;
            end
            ST_PK:  state_next = ST_PD;
            ST_PD: begin
                div_start    = 1'b1;
                div_dividend = DIV_N'(prod_reg[63:31]);
                div_len      = LEN_W'(33);
                div_divisor  = DIV_D'(field_step_reg);
                state_next   = ST_PW;
            end
            ST_PW: begin
                if (div_done) begin
                    conc_next  = div_quo[31:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next         = 1'b1;
                    out_next.cell_found    = found_reg;
                    out_next.concentration = found_reg ? conc_reg : '0;
                    out_next.wind_speed    = found_reg ? gpfp_pkg::WIND_HIT : '0;
                    out_next.cell_column   = found_reg ? ci_ext[9:0] : '0;
                    out_next.cell_row      = found_reg ? cj_ext[9:0] : '0;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_step_reg  <= gpfp_pkg::STEP_FIRST;
            field_step_reg <= '0;
            out_valid_reg  <= 1'b0;
            term_reg       <= '0;
            sqcnt_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            next_step_reg  <= next_step_next;
            field_step_reg <= field_step_next;
            out_valid_reg  <= out_valid_next;
            term_reg       <= term_next;
            sqcnt_reg      <= sqcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx0_reg   <= dx0_next;
        dy0_reg   <= dy0_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        ci_reg    <= ci_next;
        cj_reg    <= cj_next;
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
        sq_reg    <= sq_next;
        cs2_reg   <= cs2_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        found_reg <= found_next;
        conc_reg  <= conc_next;
        out_reg   <= out_next;
    end

    gpfp_div #(
        .N (DIV_N),
        .D (DIV_D)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .len      (div_len),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

[hdl/gaussian_plume_field_probe.sv]
// Top level of the plume field probe: configuration registers, front queue and back end.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_item (opcode, query_x, query_y, query_z)
//  m_       out        m_valid / m_ready    m_item (cell_found, concentration, ...)
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// An empty-grid query goes straight out; a miss or a hit before the first tick ends at
// the distance compare, a hit with an out-of-range exponent at the exponent division, and
// a hit with a concentration at the last one. The divider makes one quotient bit per
// cycle. Reset is synchronous and needs no clearing pass. While a result waits the back
// end holds in its last state, and the front queue takes new transfers until it is full.
module gaussian_plume_field_probe #(
    parameter int MAX_GRID_SIDE = gpfp_pkg::MAX_GRID_SIDE
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gpfp_pkg::in_item_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gpfp_pkg::out_item_t                m_item,
    input  logic                               cfg_wr_en,
    input  logic [gpfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpfp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    gpfp_pkg::cfg_t        cfg_reg;
    gpfp_pkg::front_head_t head;
    logic                  pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_x       <= '0;
            cfg_reg.source_y       <= '0;
            cfg_reg.cell_size      <= gpfp_pkg::RST_CELL_SIZE;
            cfg_reg.grid_columns   <= gpfp_pkg::RST_GRID_COLUMNS;
            cfg_reg.grid_rows      <= gpfp_pkg::RST_GRID_ROWS;
            cfg_reg.decay_x        <= gpfp_pkg::RST_DECAY_X;
            cfg_reg.decay_y        <= gpfp_pkg::RST_DECAY_Y;
            cfg_reg.peak_amplitude <= gpfp_pkg::RST_PEAK_AMPLITUDE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gpfp_pkg::REG_SOURCE_X:       cfg_reg.source_x       <= cfg_wdata[23:0];
                gpfp_pkg::REG_SOURCE_Y:       cfg_reg.source_y       <= cfg_wdata[23:0];
                gpfp_pkg::REG_CELL_SIZE:      cfg_reg.cell_size      <= cfg_wdata[15:0];
                gpfp_pkg::REG_GRID_COLUMNS:   cfg_reg.grid_columns   <= cfg_wdata[10:0];
                gpfp_pkg::REG_GRID_ROWS:      cfg_reg.grid_rows      <= cfg_wdata[10:0];
                gpfp_pkg::REG_DECAY_X:        cfg_reg.decay_x        <= cfg_wdata;
                gpfp_pkg::REG_DECAY_Y:        cfg_reg.decay_y        <= cfg_wdata;
                gpfp_pkg::REG_PEAK_AMPLITUDE: cfg_reg.peak_amplitude <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gpfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .head    (head),
        .pop     (pop)
    );

    gpfp_back #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[hdl/gpfp_checker.sv]
// Port-level checks for the plume field probe, bound to the top level.
module gpfp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input gpfp_pkg::in_item_t              s_item,
    input logic                            m_valid,
    input logic                            m_ready,
    input gpfp_pkg::out_item_t             m_item
);

    // A stalled input transfer must hold its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_item)))
        else $error("input changed while stalled");

    // A stalled result must hold its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result changed while stalled");

    // A miss reports all fields as zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.cell_found) |->
        (m_item.concentration == '0 && m_item.wind_speed == '0 &&
         m_item.cell_column == '0 && m_item.cell_row == '0))
        else $error("miss with nonzero fields");

    // A hit always reports the fixed wind speed.
    a_hit_wind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.cell_found) |-> (m_item.wind_speed == gpfp_pkg::WIND_HIT))
        else $error("hit with wrong wind speed");

    // No result is pending right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid out of reset");

endmodule

bind gaussian_plume_field_probe gpfp_checker u_gpfp_checker (.*);
